// ----- src/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, constants and helpers of the I2C master bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

   localparam int BITS_PER_BYTE  = 8;
   localparam int COUNTER_WIDTH  = 17;
   localparam int QPT_WIDTH      = 16;
   localparam int HOLD_WIDTH     = QPT_WIDTH + 1;
   localparam int BIT_IDX_WIDTH  = 4;
   localparam int OPCODE_WIDTH   = 3;

   localparam logic [QPT_WIDTH-1:0] QPT_RESET = QPT_WIDTH'(25);

   // queue between front and back, depth is a power of two
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OPCODE_WIDTH-1:0] OP_NONE  = 3'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_START = 3'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_STOP  = 3'd2;
   localparam logic [OPCODE_WIDTH-1:0] OP_WRITE = 3'd3;
   localparam logic [OPCODE_WIDTH-1:0] OP_READ  = 3'd4;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_ST_SCLHI = 4'd1,
      PH_ST_SDALO = 4'd2,
      PH_SP_SDALO = 4'd3,
      PH_SP_SCLHI = 4'd4,
      PH_SP_SDAHI = 4'd5,
      PH_BIT_LOW  = 4'd6,
      PH_BIT_DATA = 4'd7,
      PH_BIT_HIGH = 4'd8,
      PH_BIT_WAIT = 4'd9,
      PH_ACK_LOW  = 4'd10,
      PH_ACK_SDA  = 4'd11,
      PH_ACK_HIGH = 4'd12,
      PH_ACK_END  = 4'd13
   } phase_type;

   // one classified input item as held in the queue
   typedef struct packed {
      logic                          is_cmd;
      logic [OPCODE_WIDTH-1:0]       opcode;
      logic [BITS_PER_BYTE-1:0]      write_data;
      logic                          send_ack;
      logic                          scl_in;
      logic                          sda_in;
   } queue_item_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic           valid;
      queue_item_type item;
   } queue_head_type;

   localparam int SAT_WIDTH = HOLD_WIDTH + COUNTER_WIDTH;
   localparam logic [SAT_WIDTH-1:0] CNT_MAX_EXT =
      SAT_WIDTH'({COUNTER_WIDTH{1'b1}});

   // clamp a hold length to what the counter can hold
   function automatic logic [COUNTER_WIDTH-1:0] sat_hold(input logic [HOLD_WIDTH-1:0] n);
      logic [SAT_WIDTH-1:0] ext;
      ext = SAT_WIDTH'(n);
      if (ext > CNT_MAX_EXT) begin
         return {COUNTER_WIDTH{1'b1}};
      end
      return ext[COUNTER_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- src/i2cm_chan_if.sv -----
// ----------------------------------------------------------------------------
// i2cm channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_req_if import i2cm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OPCODE_WIDTH-1:0]   opcode;
   logic [BITS_PER_BYTE-1:0]  write_data;
   logic                      send_ack;
   logic                      scl_in;
   logic                      sda_in;

   modport source (output valid, output opcode, output write_data, output send_ack,
                   output scl_in, output sda_in, input ready);
   modport sink   (input valid, input opcode, input write_data, input send_ack,
                   input scl_in, input sda_in, output ready);
endinterface

interface i2cm_rsp_if import i2cm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      scl_out;
   logic                      sda_out;
   logic                      busy_res;
   logic                      done_res;
   logic [BITS_PER_BYTE-1:0]  read_data;
   logic                      ack_received;

   modport source (output valid, output scl_out, output sda_out, output busy_res,
                   output done_res, output read_data, output ack_received, input ready);
   modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                   input done_res, input read_data, input ack_received, output ready);
endinterface

`default_nettype wire

// ----- src/i2cm_front.sv -----
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts request items, classifies the opcode and queues them for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_front import i2cm_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   i2cm_req_if.sink        req_bus,
   input  wire logic       pop,
   output queue_head_type  head
);

   queue_item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0]     count_ff, count_in;
   logic                           push;
   queue_item_type                 new_item;

   assign req_bus.ready = (count_ff != QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign push          = req_bus.valid && req_bus.ready;

   always_comb begin
      new_item.is_cmd     = (req_bus.opcode == OP_START) || (req_bus.opcode == OP_STOP) ||
                            (req_bus.opcode == OP_WRITE) || (req_bus.opcode == OP_READ);
      new_item.opcode     = req_bus.opcode;
      new_item.write_data = req_bus.write_data;
      new_item.send_ack   = req_bus.send_ack;
      new_item.scl_in     = req_bus.scl_in;
      new_item.sda_in     = req_bus.sda_in;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ----- src/i2cm_back.sv -----
// ----------------------------------------------------------------------------
// i2cm_back
// Bit engine: steps the line sequencer once per queued item, registers result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_back import i2cm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [QPT_WIDTH-1:0]  csr_wdata,
   input  wire queue_head_type        head,
   output logic                       pop,
   i2cm_rsp_if.source                 rsp_bus
);

   logic [QPT_WIDTH-1:0]      qpt_ff;
   phase_type                 phase_ff, phase_in;
   logic [OPCODE_WIDTH-1:0]   act_ff, act_in;
   logic [BIT_IDX_WIDTH-1:0]  bit_ff, bit_in, bit_next;
   logic [BITS_PER_BYTE-1:0]  shift_ff, shift_in;
   logic [COUNTER_WIDTH-1:0]  hold_ff, hold_in;
   logic                      ack_send_ff, ack_send_in;
   logic                      scl_ff, scl_in;
   logic                      sda_ff, sda_in;
   logic                      last_ack_ff, last_ack_in;
   logic [BITS_PER_BYTE-1:0]  rx_ff, rx_in;
   logic                      done;

   logic                      out_valid_ff, out_valid_in;
   logic                      o_scl_ff, o_sda_ff, o_busy_ff, o_done_ff, o_ack_ff;
   logic [BITS_PER_BYTE-1:0]  o_rx_ff;

   logic [HOLD_WIDTH-1:0]     q_ticks;
   logic [COUNTER_WIDTH-1:0]  hold_q, hold_h;
   logic                      wr, wr_e, do_enter;
   phase_type                 enter_ph;
   queue_item_type            it;

   assign it  = head.item;
   assign pop = head.valid && (!out_valid_ff || rsp_bus.ready);

   // quarter period zero counts as one
   assign q_ticks = (qpt_ff == '0) ? HOLD_WIDTH'(1) : HOLD_WIDTH'(qpt_ff);
   assign hold_q  = sat_hold(q_ticks - 1'b1);
   assign hold_h  = sat_hold((q_ticks << 1) - 1'b1);

   always_comb begin
      phase_in    = phase_ff;
      act_in      = act_ff;
      bit_in      = bit_ff;
      bit_next    = bit_ff + 1'b1;
      shift_in    = shift_ff;
      hold_in     = hold_ff;
      ack_send_in = ack_send_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      last_ack_in = last_ack_ff;
      rx_in       = rx_ff;
      done        = 1'b0;
      do_enter    = 1'b0;
      enter_ph    = PH_IDLE;
      wr          = (act_ff == OP_WRITE);
      wr_e        = 1'b0;

      if (pop) begin
         priority if (phase_ff == PH_IDLE) begin
            if (it.is_cmd) begin
               act_in      = it.opcode;
               bit_in      = '0;
               shift_in    = (it.opcode == OP_WRITE) ? it.write_data : '0;
               ack_send_in = it.send_ack;
               do_enter    = 1'b1;
               if (it.opcode == OP_START) begin
                  enter_ph = PH_ST_SCLHI;
               end else if (it.opcode == OP_STOP) begin
                  enter_ph = PH_SP_SDALO;
               end else begin
                  enter_ph = PH_BIT_LOW;
               end
            end
         end else if (phase_ff == PH_BIT_WAIT) begin
            // clock stretching: wait until scl reads back high
            if (it.scl_in) begin
               shift_in = {shift_ff[BITS_PER_BYTE-2:0], wr ? 1'b0 : it.sda_in};
               bit_in   = bit_next;
               do_enter = 1'b1;
               if (bit_next >= BIT_IDX_WIDTH'(BITS_PER_BYTE)) begin
                  if (!wr) begin
                     rx_in = shift_in;
                  end
                  enter_ph = PH_ACK_LOW;
               end else begin
                  enter_ph = PH_BIT_LOW;
               end
            end
         end else if (hold_ff != '0) begin
            hold_in = hold_ff - 1'b1;
         end else begin
            unique case (phase_ff)
               PH_ST_SCLHI: begin do_enter = 1'b1; enter_ph = PH_ST_SDALO; end
               PH_SP_SDALO: begin do_enter = 1'b1; enter_ph = PH_SP_SCLHI; end
               PH_SP_SCLHI: begin do_enter = 1'b1; enter_ph = PH_SP_SDAHI; end
               PH_BIT_LOW: begin
                  do_enter = 1'b1;
                  enter_ph = wr ? PH_BIT_DATA : PH_BIT_HIGH;
               end
               PH_BIT_DATA: begin do_enter = 1'b1; enter_ph = PH_BIT_HIGH; end
               PH_BIT_HIGH: begin
                  phase_in = PH_BIT_WAIT;
                  hold_in  = '0;
               end
               PH_ACK_LOW: begin do_enter = 1'b1; enter_ph = PH_ACK_SDA; end
               PH_ACK_SDA: begin do_enter = 1'b1; enter_ph = PH_ACK_HIGH; end
               PH_ACK_HIGH: begin
                  if (wr) begin
                     last_ack_in = !it.sda_in;
                  end
                  do_enter = 1'b1;
                  enter_ph = PH_ACK_END;
               end
               default: begin
                  // end of start, stop or ack slot
                  phase_in = PH_IDLE;
                  act_in   = OP_NONE;
                  hold_in  = '0;
                  done     = 1'b1;
               end
            endcase
         end

         if (do_enter) begin
            wr_e     = (act_in == OP_WRITE);
            phase_in = enter_ph;
            hold_in  = hold_h;
            unique case (enter_ph)
               PH_ST_SCLHI: scl_in = 1'b1;
               PH_ST_SDALO: sda_in = 1'b0;
               PH_SP_SDALO: sda_in = 1'b0;
               PH_SP_SCLHI: begin scl_in = 1'b1; hold_in = hold_q; end
               PH_SP_SDAHI: sda_in = 1'b1;
               PH_BIT_LOW: begin
                  scl_in = 1'b0;
                  if (wr_e) begin
                     hold_in = hold_q;
                  end else begin
                     sda_in = 1'b1;
                  end
               end
               PH_BIT_DATA: sda_in = shift_in[BITS_PER_BYTE-1];
               PH_BIT_HIGH: scl_in = 1'b1;
               PH_ACK_LOW: begin scl_in = 1'b0; hold_in = hold_q; end
               PH_ACK_SDA: sda_in = wr_e ? 1'b1 : !ack_send_in;
               PH_ACK_HIGH: scl_in = 1'b1;
               PH_ACK_END: scl_in = 1'b0;
               default: begin
                  phase_in = PH_IDLE;
                  hold_in  = '0;
               end
            endcase
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qpt_ff       <= QPT_RESET;
         phase_ff     <= PH_IDLE;
         act_ff       <= OP_NONE;
         bit_ff       <= '0;
         shift_ff     <= '0;
         hold_ff      <= '0;
         ack_send_ff  <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         last_ack_ff  <= 1'b0;
         rx_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            qpt_ff <= csr_wdata;
         end
         phase_ff     <= phase_in;
         act_ff       <= act_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         hold_ff      <= hold_in;
         ack_send_ff  <= ack_send_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         last_ack_ff  <= last_ack_in;
         rx_ff        <= rx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         o_scl_ff  <= scl_in;
         o_sda_ff  <= sda_in;
         o_busy_ff <= (phase_in != PH_IDLE);
         o_done_ff <= done;
         o_rx_ff   <= rx_in;
         o_ack_ff  <= last_ack_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.scl_out      = o_scl_ff;
   assign rsp_bus.sda_out      = o_sda_ff;
   assign rsp_bus.busy_res     = o_busy_ff;
   assign rsp_bus.done_res     = o_done_ff;
   assign rsp_bus.read_data    = o_rx_ff;
   assign rsp_bus.ack_received = o_ack_ff;

endmodule

`default_nettype wire

// ----- src/i2c_bit_level_master.sv -----
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// I2C master bit engine stepped by one request item per line sample tick.
// ----------------------------------------------------------------------------
// Each request item carries an optional command (start, stop, write byte,
// read byte) and the sampled scl/sda levels of one tick. Every item yields
// exactly one result item: the scl/sda drive after that tick, busy, a done
// pulse, the last read byte and the last write ack.
// The quarter bit period in ticks is written through csr_we/csr_wdata by
// the user only while the engine is idle (not enforced); zero counts as one.
// Throughput: one item per cycle while rsp_bus.ready is high. An accepted
// item lands in a two-entry queue, the engine steps it from the queue head
// and its result is shown from the output register.
// The engine itself is a single sequencer step per item, so no item waits
// on another beyond the queue and output register.
// When rsp_bus.ready is low the result holds, the engine stops stepping and
// the queue fills; req_bus.ready drops once both queue entries are taken.
// Reset (synchronous) empties the queue and output register, sets the
// engine idle with both lines released and the quarter period to 25.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_bit_level_master import i2cm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [QPT_WIDTH-1:0]  csr_wdata,
   i2cm_req_if.sink                   req_bus,
   i2cm_rsp_if.source                 rsp_bus
);

   queue_head_type head;
   logic           pop;

   i2cm_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .pop     (pop),
      .head    (head)
   );

   i2cm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .head      (head),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

   // an accepted item is in the queue on the next cycle
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> head.valid)
      else $error("accepted item missing from queue");

   // the engine only steps when the result register can take the step
   a_pop_room: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_bus.valid)
      else $error("stepped item lost its result");

   // a finishing command leaves the engine idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.done_res) |-> !rsp_bus.busy_res)
      else $error("done reported while busy");

   // done lasts one item
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && rsp_bus.done_res)
         |=> !(rsp_bus.valid && rsp_bus.done_res))
      else $error("done longer than one item");

endmodule

`default_nettype wire

// ----- verif/tb_i2c_bit_level_master.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_bit_level_master
// Self-checking bench for the I2C master bit engine. Tick items with commands
// and sampled line levels go in through the request channel, and a line model
// in the bench predicts the result item of every tick. Both channels idle and
// stall at random, and the quarter period is changed between runs of traffic.
// ----------------------------------------------------------------------------
module tb_i2c_bit_level_master;
   import i2cm_pkg::*;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0]  opcode;
      logic [BITS_PER_BYTE-1:0] wdata;
      logic                     sack;
      logic                     scl;
      logic                     sda;
   } tick_type;

   typedef struct packed {
      logic                     scl;
      logic                     sda;
      logic                     busy;
      logic                     done;
      logic [BITS_PER_BYTE-1:0] rx;
      logic                     ack;
   } line_res_type;

   typedef struct {
      phase_type                ph;
      logic [OPCODE_WIDTH-1:0]  cmd;
      logic [BIT_IDX_WIDTH-1:0] bit_cnt;
      logic [BITS_PER_BYTE-1:0] sreg;
      logic [COUNTER_WIDTH-1:0] hold;
      logic                     ack_out;
      logic                     scl;
      logic                     sda;
      logic                     ack_in;
      logic [BITS_PER_BYTE-1:0] rx;
      logic [QPT_WIDTH-1:0]     qpt;
   } engine_type;

   typedef struct {
      tick_type    t;
      int unsigned gap;
   } pending_tick_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [QPT_WIDTH-1:0] csr_wdata;

   i2cm_req_if req_bus();
   i2cm_rsp_if rsp_bus();

   i2c_bit_level_master uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   pending_tick_type pending_ticks[$];
   line_res_type     expected_lines[$];
   engine_type       line_model;
   engine_type       plan;
   int unsigned      mismatch_count;
   int unsigned      gap_left;
   int unsigned      stall_left;
   int unsigned      req_calm;
   int unsigned      rsp_calm;
   bit               full_rate;

   always #6 clock = ~clock;

   function automatic engine_type engine_reset();
      engine_type e;
      e.ph      = PH_IDLE;
      e.cmd     = OP_NONE;
      e.bit_cnt = '0;
      e.sreg    = '0;
      e.hold    = '0;
      e.ack_out = 1'b0;
      e.scl     = 1'b1;
      e.sda     = 1'b1;
      e.ack_in  = 1'b0;
      e.rx      = '0;
      e.qpt     = QPT_RESET;
      return e;
   endfunction

   // zero quarter period counts as one, long holds clamp to the counter
   function automatic logic [COUNTER_WIDTH-1:0] hold_ticks(input logic [QPT_WIDTH-1:0] qpt,
                                                          input int unsigned quarters);
      longint unsigned q;
      longint unsigned n;
      q = (qpt == '0) ? 64'd1 : 64'(qpt);
      n = q * quarters - 1;
      if (n > (64'd1 << COUNTER_WIDTH) - 1) begin
         return '1;
      end
      return COUNTER_WIDTH'(n);
   endfunction

   function automatic void enter_phase(inout engine_type e, input phase_type p);
      logic wr;
      wr = (e.cmd == OP_WRITE);
      e.ph = p;
      e.hold = '0;
      case (p)
         PH_ST_SCLHI: begin e.scl = 1'b1; e.hold = hold_ticks(e.qpt, 2); end
         PH_ST_SDALO: begin e.sda = 1'b0; e.hold = hold_ticks(e.qpt, 2); end
         PH_SP_SDALO: begin e.sda = 1'b0; e.hold = hold_ticks(e.qpt, 2); end
         PH_SP_SCLHI: begin e.scl = 1'b1; e.hold = hold_ticks(e.qpt, 1); end
         PH_SP_SDAHI: begin e.sda = 1'b1; e.hold = hold_ticks(e.qpt, 2); end
         PH_BIT_LOW: begin
            e.scl = 1'b0;
            if (wr) begin
               e.hold = hold_ticks(e.qpt, 1);
            end else begin
               e.sda = 1'b1;
               e.hold = hold_ticks(e.qpt, 2);
            end
         end
         PH_BIT_DATA: begin e.sda = e.sreg[7]; e.hold = hold_ticks(e.qpt, 2); end
         PH_BIT_HIGH: begin e.scl = 1'b1; e.hold = hold_ticks(e.qpt, 2); end
         PH_ACK_LOW:  begin e.scl = 1'b0; e.hold = hold_ticks(e.qpt, 1); end
         PH_ACK_SDA: begin
            e.sda = wr ? 1'b1 : ~e.ack_out;
            e.hold = hold_ticks(e.qpt, 2);
         end
         PH_ACK_HIGH: begin e.scl = 1'b1; e.hold = hold_ticks(e.qpt, 2); end
         PH_ACK_END:  begin e.scl = 1'b0; e.hold = hold_ticks(e.qpt, 2); end
         default: e.ph = PH_IDLE;
      endcase
   endfunction

   // one tick of the engine, returns the result item of that tick
   function automatic line_res_type engine_tick(inout engine_type e, input tick_type t);
      line_res_type r;
      logic         fin;
      logic         wr;
      fin = 1'b0;
      wr = (e.cmd == OP_WRITE);
      if (e.ph == PH_IDLE) begin
         if (t.opcode >= OP_START && t.opcode <= OP_READ) begin
            e.cmd = t.opcode;
            e.bit_cnt = '0;
            e.sreg = (t.opcode == OP_WRITE) ? t.wdata : 8'h00;
            e.ack_out = t.sack;
            case (t.opcode)
               OP_START: enter_phase(e, PH_ST_SCLHI);
               OP_STOP:  enter_phase(e, PH_SP_SDALO);
               default:  enter_phase(e, PH_BIT_LOW);
            endcase
         end
      end else if (e.ph == PH_BIT_WAIT) begin
         // stretched clock: hold here until scl reads back high
         if (t.scl) begin
            e.sreg = wr ? {e.sreg[6:0], 1'b0} : {e.sreg[6:0], t.sda};
            e.bit_cnt = e.bit_cnt + 1'b1;
            if (e.bit_cnt >= BITS_PER_BYTE) begin
               if (!wr) begin
                  e.rx = e.sreg;
               end
               enter_phase(e, PH_ACK_LOW);
            end else begin
               enter_phase(e, PH_BIT_LOW);
            end
         end
      end else if (e.hold != '0) begin
         e.hold = e.hold - 1'b1;
      end else begin
         case (e.ph)
            PH_ST_SCLHI: enter_phase(e, PH_ST_SDALO);
            PH_SP_SDALO: enter_phase(e, PH_SP_SCLHI);
            PH_SP_SCLHI: enter_phase(e, PH_SP_SDAHI);
            PH_BIT_LOW:  enter_phase(e, wr ? PH_BIT_DATA : PH_BIT_HIGH);
            PH_BIT_DATA: enter_phase(e, PH_BIT_HIGH);
            PH_BIT_HIGH: begin
               e.ph = PH_BIT_WAIT;
               e.hold = '0;
            end
            PH_ACK_LOW:  enter_phase(e, PH_ACK_SDA);
            PH_ACK_SDA:  enter_phase(e, PH_ACK_HIGH);
            PH_ACK_HIGH: begin
               if (wr) begin
                  e.ack_in = ~t.sda;
               end
               enter_phase(e, PH_ACK_END);
            end
            default: begin
               e.ph = PH_IDLE;
               e.cmd = OP_NONE;
               e.hold = '0;
               fin = 1'b1;
            end
         endcase
      end
      r.scl  = e.scl;
      r.sda  = e.sda;
      r.busy = (e.ph != PH_IDLE);
      r.done = fin;
      r.rx   = e.rx;
      r.ack  = e.ack_in;
      return r;
   endfunction

   // wait cycles for one item, with runs of back-to-back traffic
   function automatic int unsigned draw_wait(inout int unsigned calm);
      if (full_rate) begin
         return 0;
      end
      if (calm != 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 99) == 0) begin
         calm = $urandom_range(20, 150);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   function automatic void push_tick(input tick_type t);
      pending_tick_type p;
      void'(engine_tick(plan, t));
      p.t = t;
      p.gap = draw_wait(req_calm);
      pending_ticks.push_back(p);
   endfunction

   // issue one command and tick the lines until it completes; returns the
   // number of ticks it took, zero when the command was ignored
   function automatic int unsigned run_command(input logic [OPCODE_WIDTH-1:0] op,
                                               input logic [7:0] wdata, input logic sack,
                                               input logic [7:0] slave_byte,
                                               input logic slave_ack, input bit noise);
      tick_type    t;
      int unsigned n;
      bit          finishing;
      t.opcode = op;
      t.wdata = wdata;
      t.sack = sack;
      t.scl = 1'($urandom_range(0, 1));
      t.sda = 1'($urandom_range(0, 1));
      push_tick(t);
      if (plan.ph == PH_IDLE) begin
         return 0;
      end
      n = 1;
      while (plan.ph != PH_IDLE) begin
         finishing = (plan.hold == '0) && (plan.ph == PH_ST_SDALO ||
                     plan.ph == PH_SP_SDAHI || plan.ph == PH_ACK_END);
         t.opcode = OP_NONE;
         t.wdata = 8'($urandom);
         t.sack = 1'($urandom_range(0, 1));
         t.scl = 1'($urandom_range(0, 1));
         t.sda = 1'($urandom_range(0, 1));
         if (plan.ph == PH_BIT_WAIT) begin
            t.scl = ($urandom_range(0, 3) != 0);
            t.sda = slave_byte[7 - int'(plan.bit_cnt)];
         end else if (plan.ph == PH_ACK_HIGH && plan.hold == '0) begin
            t.sda = ~slave_ack;
         end
         if (noise) begin
            if (finishing) begin
               if ($urandom_range(0, 1) == 1) begin
                  t.opcode = OPCODE_WIDTH'($urandom_range(1, 7));
               end
            end else if ($urandom_range(0, 9) == 0) begin
               t.opcode = OPCODE_WIDTH'($urandom_range(0, 7));
            end
         end
         push_tick(t);
         n++;
      end
      return n;
   endfunction

   function automatic int unsigned random_command(input logic [OPCODE_WIDTH-1:0] op);
      return run_command(op, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom),
                         1'($urandom_range(0, 1)), 1'b1);
   endfunction

   task automatic random_traffic(input int unsigned budget);
      int unsigned used;
      int unsigned nbytes;
      int unsigned k;
      tick_type    t;
      used = 0;
      while (used < budget) begin
         if ($urandom_range(0, 6) == 0) begin
            // stray command: out of order, unused opcode or none
            used += random_command(OPCODE_WIDTH'($urandom_range(0, 7)));
         end else begin
            used += random_command(OP_START);
            nbytes = $urandom_range(1, 3);
            for (k = 0; k < nbytes; k++) begin
               used += random_command(($urandom_range(0, 1) == 1) ? OP_WRITE : OP_READ);
            end
            used += random_command(OP_STOP);
         end
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               t = tick_type'($urandom);
               t.opcode = OP_NONE;
               push_tick(t);
            end
         end
      end
   endtask

   task automatic wait_quiet();
      while (pending_ticks.size() != 0 || expected_lines.size() != 0 || req_bus.valid) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic set_quarter(input logic [QPT_WIDTH-1:0] value);
      wait_quiet();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      plan.qpt = value;
      line_model.qpt = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic flag_mismatch(input string why, input line_res_type want,
                                input line_res_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected scl=%0b sda=%0b busy=%0b done=%0b rd=%02h ack=%0b",
                  why, want.scl, want.sda, want.busy, want.done, want.rx, want.ack);
         $display("   actual scl=%0b sda=%0b busy=%0b done=%0b rd=%02h ack=%0b",
                  got.scl, got.sda, got.busy, got.done, got.rx, got.ack);
      end
   endtask

   // request side: present queued items, predict each one as it is taken
   always @(posedge clock) begin : drive_req
      pending_tick_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_lines.push_back(engine_tick(line_model,
               {req_bus.opcode, req_bus.write_data, req_bus.send_ack,
                req_bus.scl_in, req_bus.sda_in}));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
               nxt = pending_ticks.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.opcode     <= nxt.t.opcode;
               req_bus.write_data <= nxt.t.wdata;
               req_bus.send_ack   <= nxt.t.sack;
               req_bus.scl_in     <= nxt.t.scl;
               req_bus.sda_in     <= nxt.t.sda;
               gap_left = nxt.gap;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result side: random back-pressure, compare against the oldest prediction
   always @(posedge clock) begin : check_rsp
      line_res_type got;
      line_res_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.scl_out, rsp_bus.sda_out, rsp_bus.busy_res, rsp_bus.done_res,
                   rsp_bus.read_data, rsp_bus.ack_received};
            if (expected_lines.size() == 0) begin
               flag_mismatch("result item with nothing expected", '0, got);
            end else begin
               want = expected_lines.pop_front();
               if (got !== want) begin
                  flag_mismatch("result item mismatch", want, got);
               end
            end
            stall_left = draw_wait(rsp_calm);
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_NONE;
      req_bus.write_data = '0;
      req_bus.send_ack = 1'b0;
      req_bus.scl_in = 1'b1;
      req_bus.sda_in = 1'b1;
      rsp_bus.ready = 1'b0;
      mismatch_count = 0;
      req_calm = 0;
      rsp_calm = 0;
      full_rate = 1'b0;
      line_model = engine_reset();
      plan = engine_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // quarter period straight out of reset
      void'(run_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0));
      void'(run_command(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0));

      // zero quarter period behaves as one
      set_quarter(16'd0);
      void'(run_command(OP_NONE, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0));
      void'(run_command(3'd5, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0));
      void'(run_command(3'd6, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0));
      void'(run_command(3'd7, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0));
      void'(run_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0));
      void'(run_command(OP_WRITE, 8'hFF, 1'b0, 8'h00, 1'b1, 1'b0));
      void'(run_command(OP_WRITE, 8'h00, 1'b1, 8'hFF, 1'b0, 1'b0));
      void'(run_command(OP_READ, 8'h00, 1'b1, 8'hFF, 1'b0, 1'b0));
      void'(run_command(OP_READ, 8'hFF, 1'b0, 8'h00, 1'b1, 1'b0));
      void'(run_command(OP_READ, 8'h3C, 1'b1, 8'h5A, 1'b0, 1'b0));
      // commands thrown in while busy and on the finishing tick
      void'(run_command(OP_WRITE, 8'hA5, 1'b0, 8'h00, 1'b1, 1'b1));
      void'(run_command(OP_READ, 8'h00, 1'b0, 8'hC3, 1'b1, 1'b1));
      void'(run_command(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1));
      void'(run_command(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0));
      void'(run_command(OP_READ, 8'h00, 1'b1, 8'h81, 1'b0, 1'b0));

      set_quarter(16'd1);
      random_traffic(100);

      // a write and a stop at full rate
      set_quarter(16'd3);
      full_rate = 1'b1;
      void'(random_command(OP_WRITE));
      void'(random_command(OP_STOP));
      wait_quiet();
      full_rate = 1'b0;

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
